### rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SIZE_W       = 27;
  localparam int unsigned ADDR_W       = 32;
  localparam logic [ADDR_W-1:0] HEADER_BYTES = 32'd32;
  localparam logic [SIZE_W-1:0] SIZE_MAX_REQ = 27'd100000000;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_CALLOC  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_NO_MEM   = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_e;

  // update broadcast from the controller to the cells
  typedef struct packed {
    logic              create;
    logic [IDX_W-1:0]  create_idx;
    logic [ADDR_W-1:0] create_base;
    logic [SIZE_W-1:0] create_size;
    logic              clr_free;
    logic [IDX_W-1:0]  clr_idx;
    logic              set_free;
    logic [IDX_W-1:0]  set_idx;
  } cell_cmd_t;

  // search key shared by all cells
  typedef struct packed {
    logic              look;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } cell_key_t;

endpackage

### rtl/core/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One block table entry; checks the passing probe and hands it to the next cell.
// ----------------------------------------------------------------------------
module ffba_cell import ffba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [CNT_W-1:0]  count_i,
  input  cell_cmd_t         cmd_i,
  input  cell_key_t         key_i,
  input  logic              probe_i,
  input  logic              kill_i,
  output logic              probe_o,
  output logic              hit_o,
  output logic [SIZE_W-1:0] hit_size_o,
  output logic [ADDR_W-1:0] hit_base_o,
  output logic              hit_free_o
);

  logic              probe_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] base_q;
  logic              free_q;
  logic              in_use;
  logic              match;
  logic [ADDR_W:0]   payload;

  // a fresh probe entering the first cell must survive the end of the last search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= 1'b0;
    end else begin
      probe_q <= probe_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.create && cmd_i.create_idx == idx_i) begin
      size_q <= cmd_i.create_size;
      base_q <= cmd_i.create_base;
      free_q <= 1'b0;
    end else if (cmd_i.clr_free && cmd_i.clr_idx == idx_i) begin
      free_q <= 1'b0;
    end else if (cmd_i.set_free && cmd_i.set_idx == idx_i) begin
      free_q <= 1'b1;
    end
  end

  assign in_use  = {1'b0, idx_i} < count_i;
  assign payload = {1'b0, base_q} + {1'b0, HEADER_BYTES};
  assign match   = key_i.look ? (payload == {1'b0, key_i.addr})
                              : (free_q && size_q >= key_i.size);

  assign probe_o    = probe_q && !kill_i;
  assign hit_o      = probe_q && in_use && match;
  assign hit_size_o = hit_o ? size_q : '0;
  assign hit_base_o = hit_o ? base_q : '0;
  assign hit_free_o = hit_o && free_q;

endmodule

### rtl/core/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over a chain of table cells with a heap break pointer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | command, size, count, address
//  out     | output    | out_valid_o/out_stall_i | status, address, copy, counts
//  cfg     | input     | APB psel/penable      | heap_base, heap_limit
//
//  one item at a time; a probe walks the cell chain one cell per cycle, and a
//  reallocate that grows its block searches twice; a zeroed allocate first
//  passes through a multiply state (S_MUL)
//  reset clears counts and sets the break to the heap_base reset value
//  a result stalled at the output holds the next update until it is taken
module first_fit_block_allocator_top import ffba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [SIZE_W-1:0] element_count_i,
  input  logic [ADDR_W-1:0] payload_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [ADDR_W-1:0] result_address_o,
  output logic [SIZE_W-1:0] copy_length_o,
  output logic [CNT_W-1:0]  free_block_count_o,
  output logic [ADDR_W-1:0] free_byte_count_o,
  output logic [CNT_W-1:0]  allocated_block_count_o,
  output logic [ADDR_W-1:0] allocated_byte_count_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_LOOK  = 5'b00100,
    S_FIT   = 5'b01000,
    S_APPLY = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]   base_reg_q, limit_reg_q;
  logic [CNT_W-1:0]    count_q, fblk_q, pos_q;
  logic [ADDR_W-1:0]   brk_q, fbytes_q, ubytes_q;

  logic [1:0]          cmd_q;
  logic [SIZE_W-1:0]   sz_q, num_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [2*SIZE_W-1:0] prod_q;
  status_e             st_q;
  logic [ADDR_W-1:0]   res_q;
  logic                fit_q, mv_q, frk_q;
  logic [IDX_W-1:0]    k_idx_q, j_idx_q;
  logic [SIZE_W-1:0]   k_size_q, j_size_q;
  logic                k_free_q, j_hit_q;
  logic [ADDR_W-1:0]   j_base_q;

  logic                out_valid_q;
  status_e             out_st_q;
  logic [ADDR_W-1:0]   out_res_q;
  logic [SIZE_W-1:0]   out_copy_q;

  logic [MAX_BLOCKS:0]   probe;
  logic [MAX_BLOCKS-1:0] hit_v, hfree_v;
  logic [SIZE_W-1:0]     hsize_v [MAX_BLOCKS];
  logic [ADDR_W-1:0]     hbase_v [MAX_BLOCKS];
  logic                  hit_any, hit_free;
  logic [SIZE_W-1:0]     hit_size;
  logic [ADDR_W-1:0]     hit_base;

  logic        accept, scan, scan_end, inject, go, bad_in, cfg_wr;
  cell_cmd_t   ccmd;
  cell_key_t   key;
  status_e     a_st;
  logic [ADDR_W-1:0] a_res;
  logic [SIZE_W-1:0] a_copy;
  logic [ADDR_W:0]   nb;

  assign accept   = in_valid_i && state_q == S_IDLE;
  assign in_stall_o = state_q != S_IDLE;
  assign scan     = state_q == S_LOOK || state_q == S_FIT;
  assign scan_end = scan && (hit_any || pos_q >= count_q);
  assign go       = state_q == S_APPLY && (!out_valid_q || !out_stall_i);
  assign bad_in   = request_size_i == '0 || request_size_i > SIZE_MAX_REQ;
  assign cfg_wr   = psel && penable && pwrite;

  // ---------------- cell chain ----------------
  assign key.look = state_q == S_LOOK;
  assign key.addr = addr_q;
  assign key.size = sz_q;
  assign probe[0] = inject;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffba_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IDX_W'(g)),
      .count_i    (count_q),
      .cmd_i      (ccmd),
      .key_i      (key),
      .probe_i    (probe[g]),
      .kill_i     (scan_end),
      .probe_o    (probe[g+1]),
      .hit_o      (hit_v[g]),
      .hit_size_o (hsize_v[g]),
      .hit_base_o (hbase_v[g]),
      .hit_free_o (hfree_v[g])
    );
  end

  // only the cell holding the probe can report a hit
  always_comb begin
    hit_size = '0;
    hit_base = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      hit_size = hit_size | hsize_v[i];
      hit_base = hit_base | hbase_v[i];
    end
  end
  assign hit_any  = |hit_v;
  assign hit_free = |hfree_v;

  // ---------------- control ----------------
  always_comb begin
    state_d = state_q;
    inject  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_ALLOC: begin
              if (bad_in) state_d = S_APPLY;
              else begin
                state_d = S_FIT;
                inject  = 1'b1;
              end
            end
            CMD_FREE: begin
              if (payload_address_i == '0) state_d = S_APPLY;
              else begin
                state_d = S_LOOK;
                inject  = 1'b1;
              end
            end
            CMD_REALLOC: begin
              if (bad_in) state_d = S_APPLY;
              else if (payload_address_i == '0) begin
                state_d = S_FIT;
                inject  = 1'b1;
              end else begin
                state_d = S_LOOK;
                inject  = 1'b1;
              end
            end
            default: state_d = S_MUL;
          endcase
        end
      end
      S_MUL: begin
        if (num_q == '0 || sz_q == '0 || prod_q > {{SIZE_W{1'b0}}, SIZE_MAX_REQ}) begin
          state_d = S_APPLY;
        end else begin
          state_d = S_FIT;
          inject  = 1'b1;
        end
      end
      S_LOOK: begin
        if (scan_end) begin
          if (hit_any && cmd_q == CMD_REALLOC && sz_q > hit_size) begin
            state_d = S_FIT;
            inject  = 1'b1;
          end else begin
            state_d = S_APPLY;
          end
        end
      end
      S_FIT: begin
        if (scan_end) state_d = S_APPLY;
      end
      S_APPLY: begin
        if (go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- final update ----------------
  assign nb = {1'b0, brk_q} + {1'b0, HEADER_BYTES} + {{(ADDR_W-SIZE_W+1){1'b0}}, sz_q};

  always_comb begin
    ccmd             = '0;
    ccmd.create_idx  = count_q[IDX_W-1:0];
    ccmd.create_base = brk_q;
    ccmd.create_size = sz_q;
    ccmd.clr_idx     = j_idx_q;
    ccmd.set_idx     = k_idx_q;
    a_st   = st_q;
    a_res  = res_q;
    a_copy = '0;
    if (fit_q) begin
      a_res = '0;
      if (j_hit_q) begin
        a_st          = ST_OK;
        a_res         = j_base_q + HEADER_BYTES;
        ccmd.clr_free = go;
      end else if (count_q >= CNT_W'(MAX_BLOCKS)) begin
        a_st = ST_FULL;
      end else if (nb > {1'b0, limit_reg_q}) begin
        a_st = ST_NO_MEM;
      end else begin
        a_st        = ST_OK;
        a_res       = brk_q + HEADER_BYTES;
        ccmd.create = go;
      end
      if (a_st == ST_OK && mv_q) begin
        a_copy        = k_size_q;
        ccmd.set_free = go && !k_free_q;
      end
    end else begin
      ccmd.set_free = go && frk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_reg_q  <= '0;
      limit_reg_q <= '1;
      count_q     <= '0;
      fblk_q      <= '0;
      brk_q       <= '0;
      fbytes_q    <= '0;
      ubytes_q    <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (inject) pos_q <= '0;
      else if (scan) pos_q <= pos_q + 1'b1;
      if (go) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (go) begin
        if (ccmd.create) begin
          count_q  <= count_q + 1'b1;
          brk_q    <= nb[ADDR_W-1:0];
          ubytes_q <= ubytes_q + ADDR_W'(sz_q);
        end
        fblk_q   <= fblk_q + CNT_W'(ccmd.set_free) - CNT_W'(ccmd.clr_free);
        fbytes_q <= fbytes_q + (ccmd.set_free ? ADDR_W'(k_size_q) : '0)
                             - (ccmd.clr_free ? ADDR_W'(j_size_q) : '0);
      end
      if (cfg_wr) begin
        if (!paddr[2]) begin
          base_reg_q <= pwdata;
          if (count_q == '0) brk_q <= pwdata;
        end else begin
          limit_reg_q <= pwdata;
        end
      end
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      sz_q   <= request_size_i;
      num_q  <= element_count_i;
      addr_q <= payload_address_i;
      prod_q <= element_count_i * request_size_i;
      st_q   <= (command_i != CMD_FREE && command_i != CMD_CALLOC && bad_in)
                ? ST_BAD_SIZE : ST_OK;
      res_q  <= '0;
      fit_q  <= state_d == S_FIT;
      mv_q   <= 1'b0;
      frk_q  <= 1'b0;
    end
    if (state_q == S_MUL) begin
      if (state_d == S_FIT) begin
        sz_q  <= prod_q[SIZE_W-1:0];
        fit_q <= 1'b1;
      end else begin
        st_q <= ST_BAD_SIZE;
      end
    end
    if (state_q == S_LOOK && scan_end) begin
      k_idx_q  <= pos_q[IDX_W-1:0];
      k_size_q <= hit_size;
      k_free_q <= hit_free;
      if (!hit_any) begin
        st_q <= ST_UNKNOWN;
      end else if (cmd_q == CMD_FREE) begin
        frk_q <= !hit_free;
      end else if (state_d == S_FIT) begin
        fit_q <= 1'b1;
        mv_q  <= 1'b1;
      end else begin
        res_q <= addr_q;
      end
    end
    if (state_q == S_FIT && scan_end) begin
      j_hit_q  <= hit_any;
      j_idx_q  <= pos_q[IDX_W-1:0];
      j_size_q <= hit_size;
      j_base_q <= hit_base;
    end
    if (go) begin
      out_st_q   <= a_st;
      out_res_q  <= a_res;
      out_copy_q <= a_copy;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign status_o                = out_st_q;
  assign result_address_o        = out_res_q;
  assign copy_length_o           = out_copy_q;
  assign free_block_count_o      = fblk_q;
  assign free_byte_count_o       = fbytes_q;
  assign allocated_block_count_o = count_q;
  assign allocated_byte_count_o  = ubytes_q;
  assign prdata                  = paddr[2] ? limit_reg_q : base_reg_q;
  assign pready                  = 1'b1;

  // ---------------- checks ----------------
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit_v))
    else $error("more than one cell reports a hit");
  a_free_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fblk_q <= count_q)
    else $error("free block count exceeds table size");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BLOCKS))
    else $error("table count overflow");
  a_no_probe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY |-> probe[MAX_BLOCKS:1] == '0)
    else $error("probe left in chain after search");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the first-fit block allocator item by item against a behavioral
// model of its block table, break pointer and running counts, over directed
// cases and random allocate/free/reallocate/zeroed-allocate traffic with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ffba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_BLOCKS + 20;
  localparam logic [2:0] REG_HEAP_BASE = 3'd0;
  localparam logic [2:0] REG_HEAP_LIMIT = 3'd4;

  typedef struct {
    logic [2:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] copy;
    logic [CNT_W-1:0]  free_blocks;
    logic [ADDR_W-1:0] free_bytes;
    logic [CNT_W-1:0]  used_blocks;
    logic [ADDR_W-1:0] used_bytes;
  } alloc_result_t;

  typedef struct {
    cmd_e              cmd;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] count;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    status_e           status;
    logic [ADDR_W-1:0] result_addr;
  } request_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        command_i = CMD_ALLOC;
  logic [SIZE_W-1:0] request_size_i = '0;
  logic [SIZE_W-1:0] element_count_i = '0;
  logic [ADDR_W-1:0] payload_address_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        status_o;
  logic [ADDR_W-1:0] result_address_o;
  logic [SIZE_W-1:0] copy_length_o;
  logic [CNT_W-1:0]  free_block_count_o;
  logic [ADDR_W-1:0] free_byte_count_o;
  logic [CNT_W-1:0]  allocated_block_count_o;
  logic [ADDR_W-1:0] allocated_byte_count_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  first_fit_block_allocator_top dut (.*);

  always #5 clk_i = ~clk_i;

  // allocator model state
  logic [ADDR_W-1:0] m_heap_base, m_heap_limit, m_break;
  logic [ADDR_W-1:0] m_base [MAX_BLOCKS];
  logic [SIZE_W-1:0] m_size [MAX_BLOCKS];
  bit                m_free [MAX_BLOCKS];
  int unsigned       m_entries;
  logic [CNT_W-1:0]  m_free_blocks;
  logic [ADDR_W-1:0] m_free_bytes, m_used_bytes;

  alloc_result_t pending_results[$];
  int unsigned   mismatches = 0;
  int unsigned   snd_idle = 0, rcv_idle = 0;
  int unsigned   hold_requests = 0;

  function automatic int find_entry(logic [ADDR_W-1:0] a);
    for (int i = 0; i < m_entries; i++)
      if ({32'd0, m_base[i]} + 64'd32 == {32'd0, a}) return i;
    return -1;
  endfunction

  function automatic void release_entry(int i);
    if (!m_free[i]) begin
      m_free[i] = 1'b1;
      m_free_blocks++;
      m_free_bytes += m_size[i];
    end
  endfunction

  function automatic status_e model_alloc(logic [31:0] sz, output logic [ADDR_W-1:0] a);
    logic [63:0] nb;
    a = '0;
    for (int i = 0; i < m_entries; i++)
      if (m_free[i] && m_size[i] >= sz) begin
        m_free[i] = 1'b0;
        m_free_blocks--;
        m_free_bytes -= m_size[i];
        a = m_base[i] + HEADER_BYTES;
        return ST_OK;
      end
    if (m_entries >= MAX_BLOCKS) return ST_FULL;
    nb = {32'd0, m_break} + 64'd32 + {32'd0, sz};
    if (nb > {32'd0, m_heap_limit}) return ST_NO_MEM;
    m_base[m_entries] = m_break;
    m_size[m_entries] = sz[SIZE_W-1:0];
    m_free[m_entries] = 1'b0;
    m_entries++;
    m_break = nb[31:0];
    m_used_bytes += sz;
    a = m_base[m_entries-1] + HEADER_BYTES;
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_alloc(request_t r);
    alloc_result_t res;
    status_e st;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] cp;
    int k;
    logic [31:0] sz, num;
    st = ST_OK; a = '0; cp = '0;
    sz = {5'd0, r.size};
    num = {5'd0, r.count};
    case (r.cmd)
      CMD_ALLOC: begin
        if (sz == 0 || sz > SIZE_MAX_REQ) st = ST_BAD_SIZE;
        else st = model_alloc(sz, a);
      end
      CMD_FREE: begin
        if (r.addr != 0) begin
          k = find_entry(r.addr);
          if (k < 0) st = ST_UNKNOWN;
          else release_entry(k);
        end
      end
      CMD_REALLOC: begin
        if (sz == 0 || sz > SIZE_MAX_REQ) st = ST_BAD_SIZE;
        else if (r.addr == 0) st = model_alloc(sz, a);
        else begin
          k = find_entry(r.addr);
          if (k < 0) st = ST_UNKNOWN;
          else if (sz <= m_size[k]) a = r.addr;
          else begin
            st = model_alloc(sz, a);
            if (st == ST_OK) begin
              cp = m_size[k];
              release_entry(k);
            end
          end
        end
      end
      default: begin
        if (num == 0 || sz == 0 || num > 32'd100000000 / sz) st = ST_BAD_SIZE;
        else st = model_alloc(num * sz, a);
      end
    endcase
    if (st != ST_OK) begin
      a = '0;
      cp = '0;
    end
    res.status = st;
    res.addr = a;
    res.copy = cp;
    res.free_blocks = m_free_blocks;
    res.free_bytes = m_free_bytes;
    res.used_blocks = m_entries[CNT_W-1:0];
    res.used_bytes = m_used_bytes;
    return res;
  endfunction

  task automatic write_reg(logic [2:0] a, logic [31:0] d);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (a == REG_HEAP_BASE) begin
      m_heap_base = d;
      if (m_entries == 0) m_break = d;
    end else begin
      m_heap_limit = d;
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(request_t r);
    alloc_result_t e;
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= r.cmd;
    request_size_i <= r.size;
    element_count_i <= r.count;
    payload_address_i <= r.addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    e = predict_alloc(r);
    if (r.typed) begin
      e.status = r.status;
      e.addr = r.result_addr;
    end
    pending_results.push_back(e);
    @(negedge clk_i);
  endtask

  function automatic request_t random_request();
    request_t r;
    int unsigned p;
    p = $urandom_range(99);
    r.cmd = p < 35 ? CMD_ALLOC : p < 65 ? CMD_FREE : p < 85 ? CMD_REALLOC : CMD_CALLOC;
    p = $urandom_range(99);
    if (p < 80) r.size = SIZE_W'($urandom_range(256, 1));
    else if (p < 92) r.size = SIZE_W'($urandom_range(100000000, 1));
    else r.size = SIZE_W'($urandom);
    r.count = ($urandom_range(9) < 8) ? SIZE_W'($urandom_range(16, 1)) : SIZE_W'($urandom);
    p = $urandom_range(99);
    if (p < 80 && m_entries > 0) r.addr = m_base[$urandom_range(m_entries - 1)] + HEADER_BYTES;
    else if (p < 90) r.addr = '0;
    else r.addr = $urandom;
    r.typed = 1'b0;
    r.status = ST_OK;
    r.result_addr = '0;
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_phase(int unsigned n, int unsigned si, int unsigned ri);
    snd_idle = si;
    rcv_idle = ri;
    repeat (n) send_item(random_request());
    in_valid_i <= 1'b0;
    wait_idle();
  endtask

  // receiver side, with one long hold-off on request
  initial begin
    int unsigned hold_left, holds_seen;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk_i);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: status %0d addr %h", status_o,
                                       result_address_o);
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status || result_address_o !== e.addr ||
            copy_length_o !== e.copy || free_block_count_o !== e.free_blocks ||
            free_byte_count_o !== e.free_bytes ||
            allocated_block_count_o !== e.used_blocks ||
            allocated_byte_count_o !== e.used_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st=%0d a=%h cp=%0d fb=%0d fB=%0d ub=%0d uB=%0d",
                     e.status, e.addr, e.copy, e.free_blocks, e.free_bytes,
                     e.used_blocks, e.used_bytes, "\n         got st=%0d a=%h cp=%0d",
                     status_o, result_address_o, copy_length_o,
                     " fb=%0d fB=%0d ub=%0d uB=%0d", free_block_count_o,
                     free_byte_count_o, allocated_block_count_o,
                     allocated_byte_count_o);
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  request_t directed [24];

  initial begin
    m_heap_base = '0;
    m_heap_limit = '1;
    m_break = '0;
    m_entries = 0;
    m_free_blocks = '0;
    m_free_bytes = '0;
    m_used_bytes = '0;
    directed = '{
      '{CMD_ALLOC,   27'd16,        27'd0,        32'h0,        1, ST_OK,       32'h1020},
      '{CMD_ALLOC,   27'd0,         27'd0,        32'h0,        1, ST_BAD_SIZE, 32'h0},
      '{CMD_ALLOC,   27'd100000001, 27'd0,        32'h0,        1, ST_BAD_SIZE, 32'h0},
      '{CMD_ALLOC,   27'h7FFFFFF,   27'h7FFFFFF,  32'hFFFFFFFF, 1, ST_BAD_SIZE, 32'h0},
      '{CMD_ALLOC,   27'd100000000, 27'd0,        32'h0,        1, ST_NO_MEM,   32'h0},
      '{CMD_FREE,    27'd0,         27'd0,        32'h0,        1, ST_OK,       32'h0},
      '{CMD_FREE,    27'd5,         27'd0,        32'h5,        1, ST_UNKNOWN,  32'h0},
      '{CMD_FREE,    27'd0,         27'd0,        32'h1020,     0, ST_OK,       32'h0},
      '{CMD_FREE,    27'd0,         27'd0,        32'h1020,     0, ST_OK,       32'h0},
      '{CMD_ALLOC,   27'd8,         27'd0,        32'h0,        0, ST_OK,       32'h0},
      '{CMD_REALLOC, 27'd4,         27'd0,        32'h1020,     0, ST_OK,       32'h0},
      '{CMD_REALLOC, 27'd64,        27'd0,        32'h1020,     0, ST_OK,       32'h0},
      '{CMD_REALLOC, 27'd5,         27'd0,        32'h0,        0, ST_OK,       32'h0},
      '{CMD_REALLOC, 27'd5,         27'd0,        32'h7,        1, ST_UNKNOWN,  32'h0},
      '{CMD_REALLOC, 27'd0,         27'd0,        32'h1020,     1, ST_BAD_SIZE, 32'h0},
      '{CMD_CALLOC,  27'd4,         27'd0,        32'h0,        1, ST_BAD_SIZE, 32'h0},
      '{CMD_CALLOC,  27'd0,         27'd4,        32'h0,        1, ST_BAD_SIZE, 32'h0},
      '{CMD_CALLOC,  27'd10000,     27'd10001,    32'h0,        1, ST_BAD_SIZE, 32'h0},
      '{CMD_CALLOC,  27'h7FFFFFF,   27'h7FFFFFF,  32'h0,        1, ST_BAD_SIZE, 32'h0},
      '{CMD_CALLOC,  27'd8,         27'd4,        32'h0,        0, ST_OK,       32'h0},
      '{CMD_CALLOC,  27'd10000,     27'd10000,    32'h0,        0, ST_OK,       32'h0},
      '{CMD_FREE,    27'd0,         27'd0,        32'hFFFFFFFF, 1, ST_UNKNOWN,  32'h0},
      '{CMD_ALLOC,   27'h4000000,   27'd0,        32'h0,        0, ST_OK,       32'h0},
      '{CMD_REALLOC, 27'd1,         27'd0,        32'hFFFFFFFF, 1, ST_UNKNOWN,  32'h0}
    };
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_reg(REG_HEAP_BASE, 32'h1000);
    write_reg(REG_HEAP_LIMIT, 32'h1200);
    snd_idle = 7;
    rcv_idle = 51;
    foreach (directed[i]) send_item(directed[i]);
    in_valid_i <= 1'b0;
    wait_idle();
    // late base write must leave the break alone
    write_reg(REG_HEAP_BASE, 32'h0);
    write_reg(REG_HEAP_LIMIT, 32'hFFFFFFFF);
    // the block fills up and stalls its input during this hold-off
    hold_requests++;
    random_phase(200, 7, 51);
    write_reg(REG_HEAP_LIMIT, 32'h0);
    random_phase(200, 51, 7);
    write_reg(REG_HEAP_BASE, 32'hFFFFFFFF);
    write_reg(REG_HEAP_LIMIT, 32'hFFFFFFFF);
    random_phase(200, 0, 0);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
